// File: hw/rtl/kpsc_pkg.sv
package kpsc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_WIDTH       = 15;
    localparam int CFG_INDEX_W     = 1;
    localparam int STATE_CODE_W    = 3;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = CFG_WIDTH'(3);
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = CFG_WIDTH'(100);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 1'b1;

    // reported key state codes
    localparam logic [STATE_CODE_W-1:0] CODE_UP       = 3'd0;
    localparam logic [STATE_CODE_W-1:0] CODE_RELEASED = 3'd1;
    localparam logic [STATE_CODE_W-1:0] CODE_PRESSED  = 3'd2;
    localparam logic [STATE_CODE_W-1:0] CODE_SHORT    = 3'd3;
    localparam logic [STATE_CODE_W-1:0] CODE_LONG     = 3'd4;

    typedef enum logic [4:0] {
        ST_UP       = 5'b00001,
        ST_RELEASED = 5'b00010,
        ST_PRESSED  = 5'b00100,
        ST_SHORT    = 5'b01000,
        ST_LONG     = 5'b10000
    } press_state_t;

    function automatic logic [STATE_CODE_W-1:0] state_code(input press_state_t st);
        logic [STATE_CODE_W-1:0] code;
        case (st)
            ST_UP:       code = CODE_UP;
            ST_RELEASED: code = CODE_RELEASED;
            ST_PRESSED:  code = CODE_PRESSED;
            ST_SHORT:    code = CODE_SHORT;
            ST_LONG:     code = CODE_LONG;
            default:     code = CODE_UP;
        endcase
        return code;
    endfunction

endpackage

// File: hw/rtl/key_press_state_classifier.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------
// s_       | s_tvalid/s_tready  | s_tdata[0] key_level, [7:1] zero
// m_       | m_tvalid/m_tready  | m_tdata[2:0] key_state, [7:3] zero
// cfg_     | cfg_we             | cfg_index, cfg_wdata (15 bits)
//
// One key sample per cycle while the output register is empty or being drained:
// the classifier state and the state code both register at the end of the accept cycle.
// A new request is taken whenever the output register is empty or being drained.
// aresetn (synchronous) clears the counter, the level and the state to steady up,
// and loads debounce 3 and long press 100.
module key_press_state_classifier #(
    parameter int COUNT_WIDTH = kpsc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [0] key_level
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [2:0] key_state
    input  logic                             cfg_we,
    input  logic [kpsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kpsc_pkg::CFG_WIDTH-1:0]   cfg_wdata
);

    // compare width covers both the counter and debounce + 1
    localparam int CMP_W = ((COUNT_WIDTH > kpsc_pkg::CFG_WIDTH + 1) ?
                            COUNT_WIDTH : kpsc_pkg::CFG_WIDTH + 1) + 1;

    logic [kpsc_pkg::CFG_WIDTH-1:0] deb_reg;
    logic [kpsc_pkg::CFG_WIDTH-1:0] lng_reg;

    logic                           level_reg, level_next;
    logic [COUNT_WIDTH-1:0]         count_reg, count_next;
    kpsc_pkg::press_state_t         state_reg, state_next;
    logic                           m_valid_reg, m_valid_next;
    logic [kpsc_pkg::STATE_CODE_W-1:0] code_reg, code_next;

    logic                           accept;
    logic                           level_in;
    logic [COUNT_WIDTH-1:0]         count_base;
    logic [COUNT_WIDTH-1:0]         count_inc;
    logic [CMP_W-1:0]               count_ext;
    logic [CMP_W-1:0]               deb_ext;
    logic [CMP_W-1:0]               deb1_ext;
    logic [CMP_W-1:0]               lng_ext;
    logic                           at_deb;
    logic                           past_deb;
    logic                           at_lng;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign level_in = s_tdata[0];

    // level change restarts the count; saturate at all ones
    assign count_base = (level_in != level_reg) ? '0 : count_reg;
    assign count_inc  = (&count_base) ? count_base : count_base + COUNT_WIDTH'(1);

    assign count_ext = CMP_W'(count_inc);
    assign deb_ext   = CMP_W'(deb_reg);
    assign deb1_ext  = CMP_W'(deb_reg) + CMP_W'(1);
    assign lng_ext   = CMP_W'(lng_reg);
    assign at_deb    = count_ext >= deb_ext;
    assign past_deb  = count_ext >= deb1_ext;
    assign at_lng    = count_ext >= lng_ext;

    always_comb begin
        level_next = level_reg;
        count_next = count_reg;
        state_next = state_reg;
        if (accept) begin
            level_next = level_in;
            if (!level_in) begin
                if (state_reg != kpsc_pkg::ST_UP) begin
                    count_next = count_inc;
                    if (past_deb) begin
                        state_next = kpsc_pkg::ST_UP;
                    end else if (at_deb) begin
                        state_next = kpsc_pkg::ST_RELEASED;
                    end
                end else begin
                    count_next = '0;
                end
            end else begin
                if (state_reg != kpsc_pkg::ST_LONG) begin
                    count_next = count_inc;
                    if (past_deb && at_lng) begin
                        state_next = kpsc_pkg::ST_LONG;
                    end else if (past_deb) begin
                        state_next = kpsc_pkg::ST_SHORT;
                    end else if (at_deb) begin
                        state_next = kpsc_pkg::ST_PRESSED;
                    end
                end else begin
                    count_next = '0;
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        code_next    = code_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            code_next    = kpsc_pkg::state_code(state_next);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg     <= kpsc_pkg::DEBOUNCE_RESET;
            lng_reg     <= kpsc_pkg::LONG_PRESS_RESET;
            level_reg   <= 1'b0;
            count_reg   <= '0;
            state_reg   <= kpsc_pkg::ST_UP;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    kpsc_pkg::REG_DEBOUNCE:   deb_reg <= cfg_wdata;
                    kpsc_pkg::REG_LONG_PRESS: lng_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            level_reg   <= level_next;
            count_reg   <= count_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - kpsc_pkg::STATE_CODE_W){1'b0}}, code_reg};

    // an accepted request always leaves a result behind
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted request produced no result");

    // released samples never leave steady up
    a_up_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !level_in && state_reg == kpsc_pkg::ST_UP)
        |=> (state_reg == kpsc_pkg::ST_UP && count_reg == '0))
        else $error("steady up left on a released sample");

    // long down is only left by a release
    a_long_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && level_in && state_reg == kpsc_pkg::ST_LONG)
        |=> (state_reg == kpsc_pkg::ST_LONG && count_reg == '0))
        else $error("long down left while pressed");

endmodule

// File: dv/key_state_checker.sv
module key_state_checker #(
    parameter int COUNT_WIDTH = kpsc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,     // [0] key_level
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [7:0]                       m_tdata,     // [2:0] key_state
    input  logic                             cfg_we,
    input  logic [kpsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kpsc_pkg::CFG_WIDTH-1:0]   cfg_wdata,
    output int                               mismatch_count,
    output int                               outstanding
);

    localparam longint unsigned TICK_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

    logic [kpsc_pkg::CFG_WIDTH-1:0]    debounce_ticks;
    logic [kpsc_pkg::CFG_WIDTH-1:0]    long_press_ticks;
    logic                              held_level;
    longint unsigned                   hold_ticks;
    logic [kpsc_pkg::STATE_CODE_W-1:0] pred_code;

    logic [kpsc_pkg::STATE_CODE_W-1:0] state_code_q[$];

    // one sampling tick of the debouncer, returns the reported state code
    function automatic logic [kpsc_pkg::STATE_CODE_W-1:0] classify_tick(input logic lvl);
        longint unsigned deb;
        longint unsigned lng;
        deb = 64'(debounce_ticks);
        lng = 64'(long_press_ticks);
        if (lvl != held_level) begin
            hold_ticks = 0;
            held_level = lvl;
        end
        if (!lvl) begin
            if (pred_code != kpsc_pkg::CODE_UP) begin
                if (hold_ticks < TICK_MAX) hold_ticks++;
                if (hold_ticks >= deb) begin
                    pred_code = (hold_ticks >= deb + 1) ? kpsc_pkg::CODE_UP
                                                        : kpsc_pkg::CODE_RELEASED;
                end
            end else begin
                hold_ticks = 0;
            end
        end else begin
            if (pred_code != kpsc_pkg::CODE_LONG) begin
                if (hold_ticks < TICK_MAX) hold_ticks++;
                if (hold_ticks >= deb) begin
                    pred_code = kpsc_pkg::CODE_PRESSED;
                    // long press only once short down has been reached
                    if (hold_ticks >= deb + 1) begin
                        pred_code = (hold_ticks >= lng) ? kpsc_pkg::CODE_LONG
                                                        : kpsc_pkg::CODE_SHORT;
                    end
                end
            end else begin
                hold_ticks = 0;
            end
        end
        return pred_code;
    endfunction

    always @(posedge aclk) begin
        logic [kpsc_pkg::STATE_CODE_W-1:0] exp_code;
        if (!aresetn) begin
            debounce_ticks   = kpsc_pkg::DEBOUNCE_RESET;
            long_press_ticks = kpsc_pkg::LONG_PRESS_RESET;
            held_level       = 1'b0;
            hold_ticks       = 0;
            pred_code        = kpsc_pkg::CODE_UP;
            mismatch_count   = 0;
            state_code_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == kpsc_pkg::REG_DEBOUNCE) debounce_ticks = cfg_wdata;
                else if (cfg_index == kpsc_pkg::REG_LONG_PRESS) long_press_ticks = cfg_wdata;
            end
            // results first: the output is registered, so a request taken on
            // this edge cannot be the one being drained
            if (m_tvalid && m_tready) begin
                if (state_code_q.size() == 0) begin
                    $error("key_state: result %0d with no request outstanding",
                           m_tdata[kpsc_pkg::STATE_CODE_W-1:0]);
                    mismatch_count++;
                end else begin
                    exp_code = state_code_q.pop_front();
                    if (m_tdata[kpsc_pkg::STATE_CODE_W-1:0] !== exp_code) begin
                        $error("key_state: expected %0d, actual %0d",
                               exp_code, m_tdata[kpsc_pkg::STATE_CODE_W-1:0]);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                state_code_q.push_back(classify_tick(s_tdata[0]));
            end
        end
        outstanding = state_code_q.size();
    end

endmodule

// File: dv/tb_top.sv
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 200;
    localparam int LONG_HOLDOFF   = 60;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [7:0]                       s_tdata;    // [0] key_level, [7:1] zero
    logic                             m_tvalid;
    logic                             m_tready;
    logic [7:0]                       m_tdata;    // [2:0] key_state, [7:3] zero
    logic                             cfg_we;
    logic [kpsc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [kpsc_pkg::CFG_WIDTH-1:0]   cfg_wdata;

    int mismatch_count;
    int outstanding;
    bit calm;
    bit hold_req;

    key_press_state_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    key_state_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result sink: short random stalls, plus one long hold-off on request
    initial begin : sink
        int n;
        bit hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLDOFF) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        @(posedge aresetn);
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle = 0;
            else idle++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_tick(input logic lvl);
        int gap;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, lvl};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic hold_level(input logic lvl, input int n);
        repeat (n) push_tick(lvl);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [kpsc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [kpsc_pkg::CFG_WIDTH-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [kpsc_pkg::CFG_WIDTH-1:0] deb,
                              input logic [kpsc_pkg::CFG_WIDTH-1:0] lng);
        drain();
        write_reg(kpsc_pkg::REG_DEBOUNCE, deb);
        write_reg(kpsc_pkg::REG_LONG_PRESS, lng);
    endtask

    initial begin : stimulus
        logic [kpsc_pkg::CFG_WIDTH-1:0] deb;
        logic [kpsc_pkg::CFG_WIDTH-1:0] lng;
        logic                           lvl;
        int                             sent;
        int                             len;
        int                             span;

        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        cfg_we    = 1'b0;
        cfg_index = kpsc_pkg::REG_DEBOUNCE;
        cfg_wdata = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;

        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset values: bounce, then clean press and release
        hold_level(1'b1, 2);
        hold_level(1'b0, 1);
        hold_level(1'b1, 4);
        hold_level(1'b0, 4);

        // zero debounce with zero long press: straight to long down / steady up
        set_config('0, '0);
        hold_level(1'b1, 2);
        hold_level(1'b0, 2);

        // long press below debounce
        set_config(kpsc_pkg::CFG_WIDTH'(4), kpsc_pkg::CFG_WIDTH'(1));
        hold_level(1'b1, 6);
        hold_level(1'b0, 5);

        // register extremes
        set_config('1, '1);
        hold_level(1'b1, 3);
        hold_level(1'b0, 2);
        set_config('0, '1);
        hold_level(1'b1, 20);
        hold_level(1'b0, 2);

        lvl = 1'b0;
        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                deb = '0;
                lng = kpsc_pkg::CFG_WIDTH'($urandom_range(0, 20));
            end else if (p == 1) begin
                deb = kpsc_pkg::CFG_WIDTH'($urandom_range(1, 8));
                lng = '0;
            end else if (p == 2) begin
                deb = kpsc_pkg::DEBOUNCE_RESET;
                lng = kpsc_pkg::LONG_PRESS_RESET;
            end else begin
                deb = kpsc_pkg::CFG_WIDTH'($urandom_range(0, 8));
                lng = kpsc_pkg::CFG_WIDTH'($urandom_range(0, 40));
            end
            set_config(deb, lng);
            calm = (p == 7);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) != 0) lvl = ~lvl;
                span = int'(deb) + int'(lng) + 4;
                if ($urandom_range(0, 9) < 7) len = $urandom_range(int'(deb) + 1, span);
                else len = $urandom_range(1, (deb > 0) ? int'(deb) : 1);
                hold_level(lvl, len);
                sent += len;
                if (p == 3 && sent >= 100 && sent - len < 100) drain();
                if (p == 4 && sent >= 50 && sent - len < 50) hold_req = 1'b1;
            end
        end

        drain();
        repeat (4) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
